/* rtl/core/hash_map_quadratic_probe_defines.svh */
// Assertion helpers for the hash map block.
// Every check is clocked on clk_i and switched off while rst_ni is low.
`ifndef HASH_MAP_QUADRATIC_PROBE_DEFINES_SVH
`define HASH_MAP_QUADRATIC_PROBE_DEFINES_SVH

// Same-cycle implication.
`define HMQP_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define HMQP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/hmqp_pkg.sv */
`timescale 1ns / 1ps

package hmqp_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 9;
  localparam int DIGIT_W    = 8;   // key bits reduced per cycle
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 9'd166;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  // slot status: bit 1 = ever used, bit 0 = tombstone
  typedef enum logic [1:0] {
    SLOT_FREE = 2'b00,
    SLOT_LIVE = 2'b10,
    SLOT_TOMB = 2'b11
  } slot_st_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_FINISH
  } back_state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [KEY_W-1:0] key;
    logic [1:0]              kind;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]        live_count;
    logic                    refused;
    logic signed [VAL_W-1:0] old_value;
    logic                    found;
  } res_t;

endpackage

/* rtl/core/hmqp_front.sv */
`timescale 1ns / 1ps

// Accepts requests and reduces |key| mod CAPACITY, one byte of the key per cycle.
module hmqp_front #(
  parameter int CAPACITY = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hmqp_pkg::req_t               in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hmqp_pkg::req_t               out_req_o,
  output logic [$clog2(CAPACITY)-1:0]  out_home_o
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int Steps = hmqp_pkg::KEY_W / hmqp_pkg::DIGIT_W;
  localparam int SW    = $clog2(Steps);
  localparam logic [IW:0]   CapW     = (IW+1)'(CAPACITY);
  localparam logic [SW-1:0] LastStep = SW'(Steps - 1);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [SW-1:0]             step_q, step_d;
  logic [hmqp_pkg::KEY_W-1:0] mag_q, mag_d;
  logic [IW-1:0]             rem_q, rem_d;
  hmqp_pkg::req_t            req_q, req_d;
  logic                      accept, push;
  logic [hmqp_pkg::KEY_W-1:0] in_mag;

  assign in_ready_o  = en_i && !busy_q && (!done_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign push        = done_q && out_ready_i;
  assign out_valid_o = done_q;
  assign out_req_o   = req_q;
  assign out_home_o  = rem_q;

  // two's complement magnitude; the minimum key maps to 2^31
  assign in_mag = in_req_i.key[hmqp_pkg::KEY_W-1] ? ((~in_req_i.key) + 32'd1) : in_req_i.key;

  always_comb begin
    logic [IW:0] r;
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    req_d  = req_q;
    r      = {1'b0, rem_q};
    // restoring reduction, MSB first
    for (int j = 0; j < hmqp_pkg::DIGIT_W; j++) begin
      r = {r[IW-1:0], mag_q[hmqp_pkg::KEY_W-1-j]};
      if (r >= CapW) begin
        r = r - CapW;
      end
    end
    if (push) begin
      done_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      step_d = '0;
      mag_d  = in_mag;
      rem_d  = '0;
      req_d  = in_req_i;
    end else if (busy_q) begin
      mag_d  = mag_q << hmqp_pkg::DIGIT_W;
      rem_d  = r[IW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    req_q <= req_d;
  end

endmodule

/* rtl/core/hmqp_queue.sv */
`timescale 1ns / 1ps

// Two-entry FIFO between front and back.
module hmqp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/hmqp_back.sv */
`timescale 1ns / 1ps

// Probe walker: slot memories, one probe per cycle, update and result register.
module hmqp_back #(
  parameter int CAPACITY = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hmqp_pkg::CNT_W-1:0]       cfg_data_i,
  output logic                             init_done_o,
  input  logic                             q_valid_i,
  output logic                             q_ready_o,
  input  hmqp_pkg::req_t                   q_req_i,
  input  logic [$clog2(CAPACITY)-1:0]      q_home_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output hmqp_pkg::res_t                   res_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);
  localparam logic [IW:0]   CapW    = (IW+1)'(CAPACITY);

  // slot storage
  logic [hmqp_pkg::KEY_W-1:0] key_mem [CAPACITY];
  logic [hmqp_pkg::VAL_W-1:0] val_mem [CAPACITY];
  hmqp_pkg::slot_st_e         st_mem  [CAPACITY];
  logic [hmqp_pkg::KEY_W-1:0] key_rd_q;
  logic [hmqp_pkg::VAL_W-1:0] val_rd_q;
  hmqp_pkg::slot_st_e         st_rd_q;

  logic [IW-1:0]              rd_addr, wr_addr;
  logic                       key_we, val_we, st_we;
  logic [hmqp_pkg::KEY_W-1:0] wr_key;
  logic [hmqp_pkg::VAL_W-1:0] wr_val;
  hmqp_pkg::slot_st_e         wr_st;

  hmqp_pkg::back_state_e      state_q, state_d;
  logic [IW-1:0]              clr_q, clr_d;
  hmqp_pkg::req_t             req_q, req_d;
  logic [IW-1:0]              pos_q, pos_d;
  logic [IW-1:0]              i_q, i_d;
  logic                       tomb_vld_q, tomb_vld_d;
  logic [IW-1:0]              tomb_q, tomb_d;
  logic                       empty_q, empty_d;
  logic                       hit_q, hit_d;
  logic [hmqp_pkg::VAL_W-1:0] hit_val_q, hit_val_d;
  logic [hmqp_pkg::CNT_W-1:0] count_q, count_d;
  logic [hmqp_pkg::CNT_W-1:0] max_q;
  logic                       out_valid_q, out_valid_d;
  hmqp_pkg::res_t             out_q, out_d;
  logic                       out_free;

  assign out_free    = !out_valid_q || res_ready_i;
  assign init_done_o = (state_q != hmqp_pkg::ST_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    logic          is_live, is_tomb, is_empty, is_hit, stop;
    logic [IW:0]   sum;
    logic [IW-1:0] next_pos;

    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    pos_d       = pos_q;
    i_d         = i_q;
    tomb_vld_d  = tomb_vld_q;
    tomb_d      = tomb_q;
    empty_d     = empty_q;
    hit_d       = hit_q;
    hit_val_d   = hit_val_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    q_ready_o   = 1'b0;
    rd_addr     = pos_q;
    wr_addr     = pos_q;
    key_we      = 1'b0;
    val_we      = 1'b0;
    st_we       = 1'b0;
    wr_key      = req_q.key;
    wr_val      = req_q.value;
    wr_st       = hmqp_pkg::SLOT_FREE;

    is_live  = (st_rd_q == hmqp_pkg::SLOT_LIVE);
    is_tomb  = (st_rd_q == hmqp_pkg::SLOT_TOMB);
    is_empty = !is_live && !is_tomb;
    is_hit   = is_live && (key_rd_q == req_q.key);
    stop     = is_empty || is_hit || (i_q == LastIdx);
    // next triangular step: pos + (i + 1), wrapped once
    sum      = {1'b0, pos_q} + {1'b0, i_q} + 1'b1;
    if (sum >= CapW) begin
      sum = sum - CapW;
    end
    next_pos = sum[IW-1:0];

    case (state_q)
      hmqp_pkg::ST_CLEAR: begin
        st_we   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == LastIdx) begin
          state_d = hmqp_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      hmqp_pkg::ST_IDLE: begin
        q_ready_o = out_free;
        rd_addr   = q_home_i;
        if (q_valid_i && out_free) begin
          case (q_req_i.kind)
            hmqp_pkg::KIND_ADD, hmqp_pkg::KIND_SEARCH, hmqp_pkg::KIND_REMOVE: begin
              req_d      = q_req_i;
              pos_d      = q_home_i;
              i_d        = '0;
              tomb_vld_d = 1'b0;
              state_d    = hmqp_pkg::ST_PROBE;
            end
            default: begin
              // unused kind: report the count, touch nothing
              out_valid_d      = 1'b1;
              out_d.found      = 1'b0;
              out_d.old_value  = '0;
              out_d.refused    = 1'b0;
              out_d.live_count = count_q;
            end
          endcase
        end
      end
      hmqp_pkg::ST_PROBE: begin
        if (is_tomb && !tomb_vld_q) begin
          tomb_vld_d = 1'b1;
          tomb_d     = pos_q;
        end
        if (stop) begin
          hit_d     = is_hit;
          hit_val_d = val_rd_q;
          empty_d   = is_empty;
          state_d   = hmqp_pkg::ST_FINISH;
        end else begin
          pos_d   = next_pos;
          i_d     = i_q + 1'b1;
          rd_addr = next_pos;
        end
      end
      hmqp_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.found     = hit_q;
          out_d.old_value = hit_q ? hit_val_q : '0;
          out_d.refused   = 1'b0;
          case (req_q.kind)
            hmqp_pkg::KIND_ADD: begin
              if (hit_q) begin
                val_we = 1'b1;
              end else if ((count_q >= max_q) || (!tomb_vld_q && !empty_q)) begin
                out_d.refused = 1'b1;
              end else begin
                // reuse the first tombstone, else the free slot that ended the walk
                wr_addr = tomb_vld_q ? tomb_q : pos_q;
                key_we  = 1'b1;
                val_we  = 1'b1;
                st_we   = 1'b1;
                wr_st   = hmqp_pkg::SLOT_LIVE;
                count_d = count_q + 1'b1;
              end
            end
            hmqp_pkg::KIND_REMOVE: begin
              if (hit_q) begin
                st_we = 1'b1;
                wr_st = hmqp_pkg::SLOT_TOMB;
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          out_d.live_count = count_d;
          state_d          = hmqp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hmqp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmqp_pkg::ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      max_q       <= hmqp_pkg::MAX_ENTRIES_RST;
      out_valid_q <= 1'b0;
      tomb_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      tomb_vld_q  <= tomb_vld_d;
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    pos_q     <= pos_d;
    i_q       <= i_d;
    tomb_q    <= tomb_d;
    empty_q   <= empty_d;
    hit_q     <= hit_d;
    hit_val_q <= hit_val_d;
    out_q     <= out_d;
  end

  // memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (st_we) begin
      st_mem[wr_addr] <= wr_st;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
    st_rd_q  <= st_mem[rd_addr];
  end

endmodule

/* rtl/core/hash_map_quadratic_probe.sv */
`timescale 1ns / 1ps

// Key-value table, open addressing with quadratic (triangular) probing and tombstones.
// Input stream: one word per request; tuser carries the kind (add, search, remove),
// tdata carries key and value. Output stream: one result word per request, in order.
// The front reduces |key| mod CAPACITY, 8 key bits per cycle, and hands the
// request to the back through a 2-deep queue, so new words are taken while the back walks.
// The front takes no new word while it is still reducing the last one.
// The back reads one slot per cycle from the slot memories; a walk ends at a hit,
// a never-used slot or after CAPACITY probes. An unused kind is answered from the
// idle state without a walk. After reset the back sweeps the slot status memory,
// all CAPACITY slots (256 by default); the input side stays not ready until the
// sweep ends. max_entries resets to 166.
// A stalled receiver holds the result register; the back then waits before writing
// its next result and the queue and front keep filling until they are full.
// The max_entries register is written by cfg_wr_en_i; write it only while idle.
module hash_map_quadratic_probe #(
  parameter int CAPACITY = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: max_entries
  input  logic                                cfg_wr_en_i,
  input  logic [hmqp_pkg::CNT_W-1:0]          cfg_wr_data_i,
  // request stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [hmqp_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,   // key[31:0], value[63:32]
  input  logic [1:0]                          s_axis_tuser_i,   // kind[1:0]
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [hmqp_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o    // found[0], old_value[32:1],
                                                                // refused[33], live_count[42:34]
);

  localparam int IW     = $clog2(CAPACITY);
  localparam int ReqW   = $bits(hmqp_pkg::req_t);
  localparam int QW     = ReqW + IW;
  localparam int OutPad = hmqp_pkg::OUT_DATA_W - $bits(hmqp_pkg::res_t);

  hmqp_pkg::req_t  in_req, f_req, b_req;
  logic [IW-1:0]   f_home, b_home;
  logic            f_valid, f_ready, b_valid, b_ready;
  logic            init_done;
  logic [QW-1:0]   q_in, q_out;
  hmqp_pkg::res_t  res;

  assign in_req.kind  = s_axis_tuser_i;
  assign in_req.key   = s_axis_tdata_i[hmqp_pkg::KEY_W-1:0];
  assign in_req.value = s_axis_tdata_i[hmqp_pkg::KEY_W +: hmqp_pkg::VAL_W];

  hmqp_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (init_done),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_req_i    (in_req),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_req_o   (f_req),
    .out_home_o  (f_home)
  );

  assign q_in   = {f_home, f_req};
  assign b_req  = q_out[ReqW-1:0];
  assign b_home = q_out[QW-1:ReqW];

  hmqp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  hmqp_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_wr_en_i),
    .cfg_data_i  (cfg_wr_data_i),
    .init_done_o (init_done),
    .q_valid_i   (b_valid),
    .q_ready_o   (b_ready),
    .q_req_i     (b_req),
    .q_home_i    (b_home),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {{OutPad{1'b0}}, res};

endmodule

/* rtl/core/hmqp_checker.sv */
`timescale 1ns / 1ps

`include "hash_map_quadratic_probe_defines.svh"

module hmqp_checker #(
  parameter int CAPACITY = 256
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [hmqp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  hmqp_pkg::res_t res;
  logic           res_vld;
  logic           out_stall;
  logic           in_take;

  assign res       = m_axis_tdata_o[$bits(hmqp_pkg::res_t)-1:0];
  assign res_vld   = m_axis_tvalid_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_take   = s_axis_tvalid_i && s_axis_tready_o;

  `HMQP_ASSERT(a_found_refused, res_vld, !(res.found && res.refused), "found with refused")
  `HMQP_ASSERT(a_miss_zero, res_vld && !res.found, res.old_value == '0, "old_value on a miss")
  `HMQP_ASSERT(a_count_cap, res_vld, 32'(res.live_count) <= CAPACITY, "count above capacity")
  `HMQP_ASSERT_NEXT(a_out_hold, out_stall, res_vld && $stable(m_axis_tdata_o), "word dropped")
  // front is busy reducing the key right after it takes a word
  `HMQP_ASSERT_NEXT(a_in_gap, in_take, !s_axis_tready_o, "ready right after a word")

endmodule

bind hash_map_quadratic_probe hmqp_checker #(
  .CAPACITY (CAPACITY)
) u_hmqp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hmqp_pkg::*;

  localparam int unsigned CAP        = 256;
  localparam int          TIMEOUT    = 3_000_000;
  localparam int          HOLD_LEN   = 300;   // long receiver stall, in cycles
  localparam int          TAIL_WAIT  = 50;    // settle time once the queue is empty
  localparam logic [1:0]  KIND_SPARE = 2'd3;  // unused kind: no effect, count only

  // Directed rows: expected fields are typed in where they are obvious,
  // otherwise the table model supplies them.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;
    logic        found;
    logic [31:0] old_value;
    logic        refused;
    logic [8:0]  live_count;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  // Block inputs, driven with NBAs on the rising edge.
  logic              cfg_en;
  logic [CNT_W-1:0]  cfg_data;
  logic              in_valid;
  logic [63:0]       in_data;     // key[31:0], value[63:32]
  logic [1:0]        in_kind;     // kind[1:0]
  logic              out_ready;

  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;  // found[0], old_value[32:1], refused[33],
                                          // live_count[42:34]

  // Shadow table: what the block should hold after every accepted word.
  logic [31:0] slot_key  [CAP];
  logic [31:0] slot_val  [CAP];
  bit          slot_used [CAP];
  bit          slot_tomb [CAP];
  logic [8:0]  live_cnt;
  logic [8:0]  max_live;

  res_t pending[$];   // results owed by the block, oldest first

  int  err_cnt;
  int  cycle_cnt;
  bit  gaps_on;
  int  hold_req;      // bumped by the stimulus side to ask for a long stall
  int  hold_seen;
  int  hold_left;
  int  fill_idx;

  dir_row_t dir_rows [22] = '{
    // misses on an empty table and the unused kind
    '{KIND_SEARCH, 32'd5,         32'd0,         1'b1, 1'b0, 32'd0,         1'b0, 9'd0},
    '{KIND_REMOVE, 32'd5,         32'd0,         1'b1, 1'b0, 32'd0,         1'b0, 9'd0},
    '{KIND_SPARE,  32'd7,         32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0,         1'b0, 9'd0},
    // insert, update at value extremes, lookup
    '{KIND_ADD,    32'd5,         32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0,         1'b0, 9'd1},
    '{KIND_ADD,    32'd5,         32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0, 9'd1},
    '{KIND_SEARCH, 32'd5,         32'd0,         1'b1, 1'b1, 32'h8000_0000, 1'b0, 9'd1},
    // -5 shares the home slot of 5; most negative key lands on slot 0
    '{KIND_ADD,    32'hFFFF_FFFB, 32'd1,         1'b1, 1'b0, 32'd0,         1'b0, 9'd2},
    '{KIND_ADD,    32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0,         1'b0, 9'd3},
    '{KIND_ADD,    32'h7FFF_FFFF, 32'd0,         1'b1, 1'b0, 32'd0,         1'b0, 9'd4},
    '{KIND_ADD,    32'd261,       32'd2,         1'b1, 1'b0, 32'd0,         1'b0, 9'd5},
    // tombstone in the middle of the chain of slot 5
    '{KIND_REMOVE, 32'hFFFF_FFFB, 32'd0,         1'b1, 1'b1, 32'd1,         1'b0, 9'd4},
    '{KIND_SEARCH, 32'd261,       32'd0,         1'b1, 1'b1, 32'd2,         1'b0, 9'd4},
    '{KIND_ADD,    32'd261,       32'd3,         1'b1, 1'b1, 32'd2,         1'b0, 9'd4},
    '{KIND_ADD,    32'd517,       32'd4,         1'b0, 1'b0, 32'd0,         1'b0, 9'd0},
    '{KIND_SEARCH, 32'd517,       32'd0,         1'b1, 1'b1, 32'd4,         1'b0, 9'd5},
    '{KIND_REMOVE, 32'h8000_0000, 32'd0,         1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 9'd4},
    '{KIND_SEARCH, 32'h8000_0000, 32'd0,         1'b1, 1'b0, 32'd0,         1'b0, 9'd4},
    '{KIND_SPARE,  32'd5,         32'h1234_5678, 1'b1, 1'b0, 32'd0,         1'b0, 9'd4},
    '{KIND_ADD,    32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'd0,         1'b0, 9'd5},
    '{KIND_REMOVE, 32'h7FFF_FFFF, 32'd0,         1'b1, 1'b1, 32'd0,         1'b0, 9'd4},
    // key 0 reuses the tombstone at slot 0; 0x80000001 walks past it
    '{KIND_ADD,    32'd0,         32'h5555_5555, 1'b0, 1'b0, 32'd0,         1'b0, 9'd0},
    '{KIND_SEARCH, 32'h8000_0001, 32'd0,         1'b0, 1'b0, 32'd0,         1'b0, 9'd0}
  };

  hash_map_quadratic_probe #(
    .CAPACITY(CAP)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_en),
    .cfg_wr_data_i   (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the shadow table and returns the result word it owes.
  // Probe i steps by i from the previous slot, which gives the triangular offsets.
  function automatic res_t probe_table(input logic [1:0] kind, input logic [31:0] key,
                                       input logic [31:0] value);
    res_t        r;
    logic [31:0] mag;
    int          pos;
    int          hit;
    int          tomb;
    int          hole;
    int          dst;
    r    = '0;
    mag  = key[31] ? (~key + 32'd1) : key;   // 0x80000000 stays 2^31
    pos  = int'(mag % CAP);
    hit  = -1;
    tomb = -1;
    hole = -1;
    if (kind != KIND_SPARE) begin
      for (int i = 0; i < CAP; i++) begin
        if (i > 0) pos = (pos + i) % CAP;
        if (!slot_used[pos]) begin
          hole = pos;
          break;
        end
        if (slot_tomb[pos]) begin
          if (tomb < 0) tomb = pos;
        end else if (slot_key[pos] == key) begin
          hit = pos;
          break;
        end
      end
      if (hit >= 0) begin
        r.found     = 1'b1;
        r.old_value = slot_val[hit];
        if (kind == KIND_ADD) begin
          slot_val[hit] = value;
        end else if (kind == KIND_REMOVE) begin
          slot_tomb[hit] = 1'b1;
          if (live_cnt > 0) live_cnt--;
        end
      end else if (kind == KIND_ADD) begin
        // whole chain checked first; then first tombstone, else the free slot
        dst = (tomb >= 0) ? tomb : hole;
        if (live_cnt >= max_live || dst < 0) begin
          r.refused = 1'b1;
        end else begin
          slot_key[dst]  = key;
          slot_val[dst]  = value;
          slot_used[dst] = 1'b1;
          slot_tomb[dst] = 1'b0;
          live_cnt++;
        end
      end
    end
    r.live_count = live_cnt;
    return r;
  endfunction

  // Presents one request word and returns on the edge that takes it.
  // tvalid stays high into the next word unless a gap is drawn.
  task automatic offer_word(input logic [1:0] kind, input logic [31:0] key,
                            input logic [31:0] value);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 34) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {value, key};
    in_kind  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic issue(input logic [1:0] kind, input logic [31:0] key,
                       input logic [31:0] value);
    offer_word(kind, key, value);
    pending.push_back(probe_table(kind, key, value));
  endtask

  // Drops tvalid and waits until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending.size() != 0);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_max(input logic [CNT_W-1:0] v);
    wait_drained();
    cfg_en   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_en   <= 1'b0;
    max_live = v;
  endtask

  // Keys: mostly a pool of 300 that crowd 40 home slots (long chains, plenty
  // of hits), plus fully random words and the magnitude extremes.
  function automatic logic [31:0] pick_key();
    int          sel;
    int          idx;
    logic [31:0] mag;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      idx = $urandom_range(0, 299);
      mag = 32'(idx % 40) * 32'd6 + 32'(idx / 40) * 32'd256;
      return ((idx / 40) % 2 == 1) ? (~mag + 32'd1) : mag;
    end
    if (sel < 90) return $urandom;
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0001;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0000;
      4:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return KIND_ADD;
    if (sel < 70) return KIND_SEARCH;
    if (sel < 95) return KIND_REMOVE;
    return KIND_SPARE;
  endfunction

  task automatic run_mix(input int n);
    repeat (n) issue(pick_kind(), pick_key(), pick_value());
  endtask

  // Result side: checks every taken word against the oldest expectation and
  // draws tready for the next cycle (random stalls or a requested long hold).
  always @(posedge clk_i) begin : rx_side
    res_t got;
    res_t want;
    if (m_axis_tvalid_o && out_ready) begin
      got = res_t'(m_axis_tdata_o[$bits(res_t)-1:0]);
      if (pending.size() == 0) begin
        $error("result word with no request outstanding: %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        want = pending.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          err_cnt++;
        end
        if (got.old_value !== want.old_value) begin
          $error("old_value: expected %h, got %h", want.old_value, got.old_value);
          err_cnt++;
        end
        if (got.refused !== want.refused) begin
          $error("refused: expected %0d, got %0d", want.refused, got.refused);
          err_cnt++;
        end
        if (got.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
          err_cnt++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > TIMEOUT) begin
      $display("hash_map_quadratic_probe verification failed");
      $finish;
    end
  end

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    cfg_en    = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    in_kind   = '0;
    out_ready = 1'b0;
    err_cnt   = 0;
    cycle_cnt = 0;
    gaps_on   = 1'b1;
    hold_req  = 0;
    hold_seen = 0;
    hold_left = 0;
    fill_idx  = 0;
    live_cnt  = '0;
    max_live  = MAX_ENTRIES_RST;
    for (int i = 0; i < CAP; i++) begin
      slot_used[i] = 1'b0;
      slot_tomb[i] = 1'b0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk at the reset limit; the block's clearing sweep just delays
    // the first handshake.
    foreach (dir_rows[i]) begin : directed
      res_t model_res;
      res_t typed_res;
      offer_word(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value);
      model_res = probe_table(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value);
      typed_res.found      = dir_rows[i].found;
      typed_res.old_value  = dir_rows[i].old_value;
      typed_res.refused    = dir_rows[i].refused;
      typed_res.live_count = dir_rows[i].live_count;
      pending.push_back(dir_rows[i].typed ? typed_res : model_res);
    end

    // Limit of one: nearly every new key is refused, updates still go through.
    write_max(9'd1);
    run_mix(150);

    // Limit above the table size: fill every slot, then only the lack of a
    // free slot refuses. Absent keys walk the full chain.
    write_max(9'h1FF);
    while (live_cnt < CAP) begin
      issue(KIND_ADD, 32'h4000_0000 + 32'(fill_idx), pick_value());
      fill_idx++;
    end
    issue(KIND_ADD, 32'h3000_0000, pick_value());
    issue(KIND_SEARCH, 32'h3000_0001, 32'd0);
    issue(KIND_ADD, 32'h4000_0000, 32'hFFFF_FFFF);
    issue(KIND_REMOVE, 32'h4000_0000, 32'd0);
    issue(KIND_ADD, 32'h3000_0000, 32'h0000_0000);
    issue(KIND_SEARCH, 32'h3000_0000, 32'd0);
    run_mix(250);

    // Limit zero: no new key is ever admitted.
    write_max(9'd0);
    run_mix(150);

    // Limit equal to the table size, no idling on either side.
    write_max(9'd256);
    gaps_on = 1'b0;
    run_mix(300);
    gaps_on = 1'b1;

    // Back at the reset value: receiver stalls long while words keep coming,
    // so the front queue fills and tready drops; then a full drain pause.
    write_max(MAX_ENTRIES_RST);
    hold_req <= hold_req + 1;
    run_mix(40);
    wait_drained();
    run_mix(400);

    write_max(CNT_W'($urandom_range(1, 256)));
    run_mix(350);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("hash_map_quadratic_probe verification clean");
    end else begin
      $display("hash_map_quadratic_probe verification failed");
    end
    $finish;
  end

endmodule
